// ===== design/afm_pkg.sv =====
// ----------------------------------------------------------------------------
// afm_pkg
// Shared widths, constants and command/status types of the adaptive model.
// ----------------------------------------------------------------------------
package afm_pkg;

  localparam int NumChars   = 256;
  localparam int NumSymbols = 257;
  localparam int CountWidth = 16;
  localparam int PosWidth   = 9;
  localparam int Depth      = NumSymbols + 1;

  localparam logic [CountWidth-1:0] ResetLimit = CountWidth'(16383);

  // table walk operations requested by the controller
  typedef enum logic [2:0] {
    OpNone,
    OpInit,
    OpRead,
    OpHalve,
    OpSearch,
    OpSwap,
    OpBump
  } afm_op_e;

  typedef struct packed {
    afm_op_e              op;
    logic [PosWidth-1:0]  addr;
    logic                 first;
    logic                 latch_out;
  } afm_cmd_t;

  typedef struct packed {
    logic                 freq_equal;
    logic [CountWidth-1:0] total;
  } afm_sts_t;

endpackage

// ===== design/afm_datapath.sv =====
// ----------------------------------------------------------------------------
// afm_datapath
// Table memories and the per-entry update logic of the adaptive model.
// ----------------------------------------------------------------------------
module afm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  afm_pkg::afm_cmd_t                 cmd_i,
  output afm_pkg::afm_sts_t                 sts_o,
  output logic [afm_pkg::PosWidth-1:0]      symbol_code_o,
  output logic [afm_pkg::CountWidth-1:0]    interval_low_o,
  output logic [afm_pkg::CountWidth-1:0]    interval_high_o,
  output logic [afm_pkg::CountWidth-1:0]    total_count_o
);

  localparam int CW = afm_pkg::CountWidth;
  localparam int PW = afm_pkg::PosWidth;

  logic [CW-1:0] freq_mem [afm_pkg::Depth];
  logic [CW-1:0] cum_mem  [afm_pkg::Depth];
  logic [PW-1:0] p2c_mem  [afm_pkg::Depth];

  afm_pkg::afm_cmd_t cmd_q;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] prev_freq_q;
  logic [CW-1:0] total_q;
  logic [CW-1:0] total_hold_q;
  logic [PW-1:0] code_q;
  logic [CW-1:0] low_q, high_q;
  logic [PW-1:0] held_code_q;

  logic [CW-1:0] freq_rd_q, half;
  logic [CW-1:0] cum_rd_q;
  logic [PW-1:0] p2c_rd_q;

  // second stage works on the entry read for the command of the last cycle
  always_comb begin
    half  = CW'(({1'b0, freq_rd_q} + {{CW{1'b0}}, 1'b1}) >> 1);
    run_d = cmd_q.first ? half : run_q + half;
  end

  // search walks downward: compare entry at q-1 with entry at q read first
  assign sts_o.freq_equal = (freq_rd_q == prev_freq_q);
  assign sts_o.total      = total_q;

  always_ff @(posedge clk_i) begin
    freq_rd_q <= freq_mem[cmd_i.addr];
    cum_rd_q  <= cum_mem[cmd_i.addr];
    p2c_rd_q  <= p2c_mem[cmd_i.addr];
    unique case (cmd_q.op)
      afm_pkg::OpInit: begin
        freq_mem[cmd_q.addr] <= (cmd_q.addr == '0) ? '0 : CW'(1);
        cum_mem[cmd_q.addr]  <= CW'(afm_pkg::NumSymbols) - CW'(cmd_q.addr);
        p2c_mem[cmd_q.addr]  <= (cmd_q.addr == '0) ? '0 : cmd_q.addr - PW'(1);
      end
      afm_pkg::OpRead: begin
        if (cmd_q.first) begin
          code_q       <= p2c_rd_q;
          low_q        <= cum_rd_q;
          total_hold_q <= total_q;
        end else begin
          high_q <= cum_rd_q;
        end
      end
      afm_pkg::OpHalve: begin
        freq_mem[cmd_q.addr] <= half;
        cum_mem[cmd_q.addr]  <= cmd_q.first ? '0 : run_q;
      end
      afm_pkg::OpSearch: begin
        if (cmd_q.first) prev_freq_q <= freq_rd_q;
      end
      afm_pkg::OpSwap: begin
        // first: read entry at q and write code from p; second: write p
        if (cmd_q.first) begin
          held_code_q          <= p2c_rd_q;
          p2c_mem[cmd_q.addr]  <= code_q;
        end else begin
          p2c_mem[cmd_q.addr] <= held_code_q;
        end
      end
      afm_pkg::OpBump: begin
        // frequency at q, cumulative counts below q
        if (cmd_q.first) freq_mem[cmd_q.addr] <= freq_rd_q + CW'(1);
        else cum_mem[cmd_q.addr] <= cum_rd_q + CW'(1);
      end
      default: begin
      end
    endcase
    if (cmd_i.latch_out) begin
      symbol_code_o   <= code_q;
      interval_low_o  <= low_q;
      interval_high_o <= high_q;
      total_count_o   <= total_hold_q;
    end
  end

  // halve pass runs top down, so the running sum covers entries above
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= '{op: afm_pkg::OpNone, addr: '0, first: 1'b0, latch_out: 1'b0};
      run_q   <= '0;
      total_q <= CW'(afm_pkg::NumSymbols);
    end else begin
      cmd_q <= cmd_i;
      if (cmd_q.op == afm_pkg::OpHalve) begin
        run_q <= run_d;
        if (cmd_q.addr == '0) total_q <= run_q;
      end else if (cmd_q.op == afm_pkg::OpBump && !cmd_q.first && cmd_q.addr == '0) begin
        total_q <= cum_rd_q + CW'(1);
      end else if (cmd_q.op == afm_pkg::OpInit) begin
        total_q <= CW'(afm_pkg::NumSymbols);
      end
    end
  end

endmodule

// ===== design/afm_ctrl.sv =====
// ----------------------------------------------------------------------------
// afm_ctrl
// Sequencer: init sweep, read, optional halve sweep, search, optional swap, bump sweep.
// ----------------------------------------------------------------------------
module afm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [afm_pkg::PosWidth-1:0]    symbol_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [afm_pkg::CountWidth-1:0]  rescale_limit_i,
  input  afm_pkg::afm_sts_t               sts_i,
  output afm_pkg::afm_cmd_t               cmd_o,
  output logic [afm_pkg::PosWidth-1:0]    new_position_o,
  output logic                            was_rescaled_o
);

  localparam int PW = afm_pkg::PosWidth;

  typedef enum logic [3:0] {
    StInit, StIdle, StRdLow, StRdHigh, StCheck, StHalve, StSearch0, StSearch,
    StCompare, StSwapQ, StSwapP, StBump, StDone
  } state_e;

  state_e        state_q;
  logic [PW-1:0] p_q, q_q, addr_q;
  logic          resc_q;
  logic          out_free, load_out, take_out;

  assign in_stall_o = (state_q != StIdle);
  // output register is free when empty or being taken this cycle
  assign take_out   = out_valid_o && !out_stall_i;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign load_out   = (state_q == StDone) && out_free;

  always_comb begin
    cmd_o = '{op: afm_pkg::OpNone, addr: addr_q, first: 1'b0, latch_out: 1'b0};
    unique case (state_q)
      StInit:    cmd_o.op = afm_pkg::OpInit;
      StRdLow:   begin cmd_o.op = afm_pkg::OpRead; cmd_o.addr = p_q; cmd_o.first = 1'b1; end
      StRdHigh:  begin cmd_o.op = afm_pkg::OpRead; cmd_o.addr = p_q - PW'(1); end
      StHalve:   begin
        cmd_o.op = afm_pkg::OpHalve;
        cmd_o.first = (addr_q == PW'(afm_pkg::NumSymbols));
      end
      StSearch0: begin cmd_o.op = afm_pkg::OpSearch; cmd_o.addr = q_q; cmd_o.first = 1'b1; end
      StSearch:  begin cmd_o.op = afm_pkg::OpSearch; cmd_o.addr = q_q - PW'(1); end
      StSwapQ:   begin cmd_o.op = afm_pkg::OpSwap; cmd_o.addr = q_q; cmd_o.first = 1'b1; end
      StSwapP:   begin cmd_o.op = afm_pkg::OpSwap; cmd_o.addr = p_q; end
      StBump:    begin cmd_o.op = afm_pkg::OpBump; cmd_o.first = (addr_q == q_q); end
      StDone:    cmd_o.latch_out = out_free;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StInit;
      addr_q         <= '0;
      p_q            <= '0;
      q_q            <= '0;
      resc_q         <= 1'b0;
      out_valid_o    <= 1'b0;
      new_position_o <= '0;
      was_rescaled_o <= 1'b0;
    end else begin
      unique case (state_q)
        StInit: begin
          addr_q <= addr_q + PW'(1);
          if (addr_q == PW'(afm_pkg::NumSymbols)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i && symbol_index_i != '0 &&
              symbol_index_i <= PW'(afm_pkg::NumSymbols)) begin
            p_q     <= symbol_index_i;
            state_q <= StRdLow;
          end
        end
        StRdLow:  state_q <= StRdHigh;
        StRdHigh: state_q <= StCheck;
        StCheck: begin
          resc_q <= (sts_i.total == rescale_limit_i);
          q_q    <= p_q;
          addr_q <= PW'(afm_pkg::NumSymbols);
          state_q <= (sts_i.total == rescale_limit_i) ? StHalve : StSearch0;
        end
        StHalve: begin
          addr_q <= addr_q - PW'(1);
          if (addr_q == '0) state_q <= StSearch0;
        end
        StSearch0: begin
          if (q_q > PW'(1)) begin
            state_q <= StSearch;
          end else begin
            addr_q  <= q_q;
            state_q <= StBump;
          end
        end
        // StSearch issues the read of the entry below q; its registered data is compared in StCompare
        StSearch: state_q <= StCompare;
        StCompare: begin
          if (sts_i.freq_equal) begin
            q_q     <= q_q - PW'(1);
            state_q <= (q_q == PW'(2)) ? StSwapQ : StSearch;
          end else if (q_q < p_q) begin
            state_q <= StSwapQ;
          end else begin
            addr_q  <= q_q;
            state_q <= StBump;
          end
        end
        StSwapQ: state_q <= StSwapP;
        StSwapP: begin
          state_q <= StBump;
          addr_q  <= q_q;
        end
        StBump: begin
          if (addr_q == '0) state_q <= StDone;
          else addr_q <= addr_q - PW'(1);
        end
        StDone: begin
          if (out_free) begin
            new_position_o <= q_q;
            was_rescaled_o <= resc_q;
            state_q        <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (load_out) out_valid_o <= 1'b1;
      else if (take_out) out_valid_o <= 1'b0;
    end
  end

endmodule

// ===== design/adaptive_frequency_model.sv =====
// ----------------------------------------------------------------------------
// adaptive_frequency_model
// Adaptive symbol model of an arithmetic coder: interval lookup and update.
//
//   channel   direction  handshake                 word
//   input     in         in_valid_i / in_stall_o   symbol_index_i
//   output    out        out_valid_o / out_stall_i interval, code, position
//   config    in         rescale_limit_we_i        rescale_limit_i
//
// one word at a time; the time from accept to accept grows with the new position,
// with each search compare, with a swap and with a halve sweep
// the init, halve and bump sweeps walk one entry a cycle over up to 258 entries
// after reset an init sweep over all 258 entries fills the tables; input stalls then
// input stalls from acceptance until the result word is loaded, which waits
// only while the previous word is still held at the output
// ----------------------------------------------------------------------------
module adaptive_frequency_model (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [afm_pkg::PosWidth-1:0]    symbol_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [afm_pkg::PosWidth-1:0]    symbol_code_o,
  output logic [afm_pkg::CountWidth-1:0]  interval_low_o,
  output logic [afm_pkg::CountWidth-1:0]  interval_high_o,
  output logic [afm_pkg::CountWidth-1:0]  total_count_o,
  output logic [afm_pkg::PosWidth-1:0]    new_position_o,
  output logic                            was_rescaled_o,
  input  logic                            rescale_limit_we_i,
  input  logic [afm_pkg::CountWidth-1:0]  rescale_limit_i
);

  logic [afm_pkg::CountWidth-1:0] limit_q;
  afm_pkg::afm_cmd_t              cmd;
  afm_pkg::afm_sts_t              sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= afm_pkg::ResetLimit;
    else if (rescale_limit_we_i) limit_q <= rescale_limit_i;
  end

  afm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .symbol_index_i,
    .out_valid_o, .out_stall_i, .rescale_limit_i(limit_q),
    .sts_i(sts), .cmd_o(cmd), .new_position_o, .was_rescaled_o
  );

  afm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .symbol_code_o, .interval_low_o, .interval_high_o, .total_count_o
  );

endmodule

// ===== tb/sv/tb_adaptive_frequency_model.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_frequency_model
// Drives symbol indices into the adaptive model with random gaps and output
// stalls, predicts every result word from a local copy of the frequency and
// cumulative tables, and compares each taken word field by field. Phases
// switch the rescale limit between extremes, below-total and reachable values.
// ----------------------------------------------------------------------------
module tb_adaptive_frequency_model;

  typedef logic [afm_pkg::PosWidth-1:0]   pos_t;
  typedef logic [afm_pkg::CountWidth-1:0] cnt_t;

  typedef struct packed {
    pos_t code;
    cnt_t low;
    cnt_t high;
    cnt_t total;
    pos_t new_pos;
    logic rescaled;
  } interval_t;

  typedef struct {
    pos_t      idx;
    bit        typed;
    interval_t word;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pos_t symbol_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pos_t symbol_code_o;
  cnt_t interval_low_o, interval_high_o, total_count_o;
  pos_t new_position_o;
  logic was_rescaled_o;
  logic rescale_limit_we_i = 1'b0;
  cnt_t rescale_limit_i = '0;

  adaptive_frequency_model dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // local model state
  cnt_t freq_tab [0:afm_pkg::NumSymbols];
  cnt_t cum_tab  [0:afm_pkg::NumSymbols];
  pos_t char_pos [0:afm_pkg::NumSymbols-1];
  pos_t pos_char [0:afm_pkg::NumSymbols];
  cnt_t limit_q;

  interval_t pending_q[$];
  int  errors = 0;
  bit  quiet = 0;

  function automatic bit model_update(input pos_t p, output interval_t w);
    int q;
    cnt_t run;
    pos_t c_here, c_moved;
    if (p == 0 || p > afm_pkg::NumSymbols) return 0;
    w.code  = pos_char[p];
    w.low   = cum_tab[p];
    w.high  = cum_tab[p-1];
    w.total = cum_tab[0];
    w.rescaled = 1'b0;
    if (cum_tab[0] == limit_q) begin
      run = '0;
      for (int k = afm_pkg::NumSymbols; k >= 0; k--) begin
        freq_tab[k] = cnt_t'(({1'b0, freq_tab[k]} + 1) >> 1);
        cum_tab[k]  = run;
        run = run + freq_tab[k];
      end
      w.rescaled = 1'b1;
    end
    q = p;
    while (q > 1 && freq_tab[q] == freq_tab[q-1]) q--;
    if (q < p) begin
      c_here  = pos_char[q];
      c_moved = pos_char[p];
      pos_char[q] = c_moved;
      pos_char[p] = c_here;
      if (c_here < afm_pkg::NumSymbols) char_pos[c_here] = p;
      if (c_moved < afm_pkg::NumSymbols) char_pos[c_moved] = pos_t'(q);
    end
    freq_tab[q] = freq_tab[q] + 1'b1;
    for (int k = 0; k < q; k++) cum_tab[k] = cum_tab[k] + 1'b1;
    w.new_pos = pos_t'(q);
    return 1;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: random stall bursts, compare each taken word
  int stall_left = 0;
  always @(posedge clk_i) begin
    interval_t e;
    if (out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word: expected none actual code %0d low %0d", $time,
                 symbol_code_o, interval_low_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        check_field("symbol_code", e.code, symbol_code_o);
        check_field("interval_low", e.low, interval_low_o);
        check_field("interval_high", e.high, interval_high_o);
        check_field("total_count", e.total, total_count_o);
        check_field("new_position", e.new_pos, new_position_o);
        check_field("was_rescaled", e.rescaled, was_rescaled_o);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_word(input pos_t idx, input bit typed, input interval_t tw);
    interval_t w;
    in_valid_i     <= 1'b1;
    symbol_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    if (model_update(idx, w)) pending_q.push_back(typed ? tw : w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic set_limit(input cnt_t v);
    in_valid_i <= 1'b0;
    wait (pending_q.size() == 0);
    // an ignored index may still be in flight
    repeat (600) @(posedge clk_i);
    rescale_limit_we_i <= 1'b1;
    rescale_limit_i    <= v;
    @(posedge clk_i);
    rescale_limit_we_i <= 1'b0;
    limit_q = v;
  endtask

  function automatic pos_t random_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pos_t'($urandom_range(1, 6));
    if (r < 9) return pos_t'($urandom_range(1, afm_pkg::NumSymbols));
    return pos_t'($urandom_range(0, 511));
  endfunction

  task automatic random_phase(input int n);
    interval_t none;
    none = '0;
    for (int i = 0; i < n; i++) send_word(random_index(), 1'b0, none);
  endtask

  stim_row_t rows[$];

  initial begin
    interval_t none;
    none = '0;
    for (int k = 0; k <= afm_pkg::NumSymbols; k++) begin
      freq_tab[k] = (k == 0) ? cnt_t'(0) : cnt_t'(1);
      cum_tab[k]  = cnt_t'(afm_pkg::NumSymbols - k);
      pos_char[k] = (k == 0) ? pos_t'(0) : pos_t'(k - 1);
    end
    pos_char[afm_pkg::NumSymbols] = pos_t'(afm_pkg::NumChars);
    for (int k = 0; k < afm_pkg::NumSymbols; k++) char_pos[k] = pos_t'(k + 1);
    limit_q = afm_pkg::ResetLimit;

    // end of stream first: all frequencies equal, so it moves to position 1
    rows.push_back('{pos_t'(257), 1'b1, '{pos_t'(256), cnt_t'(0), cnt_t'(1),
                                           cnt_t'(257), pos_t'(1), 1'b0}});
    rows.push_back('{pos_t'(0),   1'b0, none});
    rows.push_back('{pos_t'(258), 1'b0, none});
    rows.push_back('{pos_t'(511), 1'b0, none});
    rows.push_back('{pos_t'(1),   1'b0, none});
    rows.push_back('{pos_t'(2),   1'b0, none});
    rows.push_back('{pos_t'(256), 1'b0, none});
    rows.push_back('{pos_t'(257), 1'b0, none});
    rows.push_back('{pos_t'(128), 1'b0, none});
    rows.push_back('{pos_t'(255), 1'b0, none});
    rows.push_back('{pos_t'(3),   1'b0, none});
    rows.push_back('{pos_t'(1),   1'b0, none});
    rows.push_back('{pos_t'(2),   1'b0, none});
    rows.push_back('{pos_t'(170), 1'b0, none});
    rows.push_back('{pos_t'(85),  1'b0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_word(rows[i].idx, rows[i].typed, rows[i].word);

    set_limit(cnt_t'(65535));
    random_phase(150);
    set_limit(cnt_t'(300));           // already below the total
    random_phase(100);
    set_limit(cnt_t'(cum_tab[0] + 60));
    random_phase(250);
    set_limit(cnt_t'(258));
    random_phase(100);
    set_limit(cnt_t'(cum_tab[0] + 20));
    random_phase(150);
    quiet = 1;
    random_phase(100);
    in_valid_i <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (600) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
